// ===== rtl/a2m_pkg.sv =====
// ----------------------------------------------------------------------------
// a2m_pkg
// Shared types, constants and the character lookup for the Morse encoder.
// ----------------------------------------------------------------------------
package a2m_pkg;

    // Output symbol codes
    localparam logic [1:0] SymDot  = 2'd0;
    localparam logic [1:0] SymDash = 2'd1;
    localparam logic [1:0] SymGap  = 2'd2;
    localparam logic [1:0] SymWord = 2'd3;

    // Character codes with special handling
    localparam logic [7:0] CharSpace   = 8'h20;
    localparam logic [7:0] CharNewline = 8'h0A;
    localparam logic [7:0] CharSlash   = 8'h2F;
    localparam logic [7:0] CharLowA    = 8'h61;
    localparam logic [7:0] CharLowZ    = 8'h7A;
    localparam logic [7:0] CaseOffset  = 8'd32;

    // Default depth of the queue between front and back
    localparam int QDepth = 2;

    // Work descriptor: elements left-aligned, bit 5 first, 1 = dash
    typedef struct packed {
        logic       word;
        logic [2:0] len;
        logic [5:0] pat;
    } t_desc;

    typedef struct packed {
        logic  keep;
        t_desc desc;
    } t_class;

    function automatic t_class mk(input logic [2:0] len, input logic [5:0] pat);
        t_class r;
        r.keep      = 1'b1;
        r.desc.word = 1'b0;
        r.desc.len  = len;
        r.desc.pat  = pat;
        return r;
    endfunction

    // Classify one character into its Morse descriptor
    function automatic t_class classify(input logic [7:0] code);
        t_class     r;
        logic [7:0] c;
        r = '0;
        c = code;
        if (c >= CharLowA && c <= CharLowZ) begin
            c = c - CaseOffset;
        end
        unique case (c)
            CharSpace: begin
                r.keep      = 1'b1;
                r.desc.word = 1'b1;
                r.desc.len  = 3'd1;
                r.desc.pat  = '0;
            end
            CharNewline: r = '0;
            8'h41: r = mk(3'd2, 6'b010000); // A
            8'h42: r = mk(3'd4, 6'b100000); // B
            8'h43: r = mk(3'd4, 6'b101000); // C
            8'h44: r = mk(3'd3, 6'b100000); // D
            8'h45: r = mk(3'd1, 6'b000000); // E
            8'h46: r = mk(3'd4, 6'b001000); // F
            8'h47: r = mk(3'd3, 6'b110000); // G
            8'h48: r = mk(3'd4, 6'b000000); // H
            8'h49: r = mk(3'd2, 6'b000000); // I
            8'h4A: r = mk(3'd4, 6'b011100); // J
            8'h4B: r = mk(3'd3, 6'b101000); // K
            8'h4C: r = mk(3'd4, 6'b010000); // L
            8'h4D: r = mk(3'd2, 6'b110000); // M
            8'h4E: r = mk(3'd2, 6'b100000); // N
            8'h4F: r = mk(3'd3, 6'b111000); // O
            8'h50: r = mk(3'd4, 6'b011000); // P
            8'h51: r = mk(3'd4, 6'b110100); // Q
            8'h52: r = mk(3'd3, 6'b010000); // R
            8'h53: r = mk(3'd3, 6'b000000); // S
            8'h54: r = mk(3'd1, 6'b100000); // T
            8'h55: r = mk(3'd3, 6'b001000); // U
            8'h56: r = mk(3'd4, 6'b000100); // V
            8'h57: r = mk(3'd3, 6'b011000); // W
            8'h58: r = mk(3'd4, 6'b100100); // X
            8'h59: r = mk(3'd4, 6'b101100); // Y
            8'h5A: r = mk(3'd4, 6'b110000); // Z
            8'h30: r = mk(3'd5, 6'b111110); // 0
            8'h31: r = mk(3'd5, 6'b011110); // 1
            8'h32: r = mk(3'd5, 6'b001110); // 2
            8'h33: r = mk(3'd5, 6'b000110); // 3
            8'h34: r = mk(3'd5, 6'b000010); // 4
            8'h35: r = mk(3'd5, 6'b000000); // 5
            8'h36: r = mk(3'd5, 6'b100000); // 6
            8'h37: r = mk(3'd5, 6'b110000); // 7
            8'h38: r = mk(3'd5, 6'b111000); // 8
            8'h39: r = mk(3'd5, 6'b111100); // 9
            8'h2E: r = mk(3'd6, 6'b010101); // period
            8'h2C: r = mk(3'd6, 6'b110011); // comma
            8'h3A: r = mk(3'd6, 6'b111000); // colon
            8'h3F: r = mk(3'd6, 6'b001100); // question mark
            8'h2D: r = mk(3'd6, 6'b100001); // hyphen
            CharSlash: r = mk(3'd5, 6'b100100);
            8'h3B: r = mk(3'd6, 6'b101010); // semicolon
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/a2m_ifs.sv =====
// ----------------------------------------------------------------------------
// a2m_ifs
// Valid/ready channel interfaces for characters in and Morse symbols out.
// ----------------------------------------------------------------------------
interface a2m_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface a2m_sym_if;
    logic       valid;
    logic       ready;
    logic [1:0] symbol;
    logic       last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ===== rtl/a2m_front.sv =====
// ----------------------------------------------------------------------------
// a2m_front
// Accepts characters, looks up their Morse descriptor and pushes kept ones.
// ----------------------------------------------------------------------------
module a2m_front (
    a2m_char_if.sink       i_char,
    input  logic           i_full,
    output logic           o_push,
    output a2m_pkg::t_desc o_push_desc
);
    import a2m_pkg::*;

    t_class cls;

    // Classify the incoming character
    assign cls = classify(i_char.char_code);

    // Accept while the queue has room; drop characters with no pattern
    assign i_char.ready = !i_full;
    assign o_push       = i_char.valid && !i_full && cls.keep;
    assign o_push_desc  = cls.desc;
endmodule

// ===== rtl/a2m_queue.sv =====
// ----------------------------------------------------------------------------
// a2m_queue
// Small FIFO of descriptors between the front and back parts.
// ----------------------------------------------------------------------------
module a2m_queue #(
    parameter int Depth = a2m_pkg::QDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  a2m_pkg::t_desc i_push_desc,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output a2m_pkg::t_desc o_desc
);
    import a2m_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

    t_desc            r_mem [Depth];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]  r_count, n_count;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end
endmodule

// ===== rtl/a2m_back.sv =====
// ----------------------------------------------------------------------------
// a2m_back
// Serializes one descriptor into dots, dashes, separators and a final gap.
// ----------------------------------------------------------------------------
module a2m_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  a2m_pkg::t_desc i_q_desc,
    output logic           o_pop,
    a2m_sym_if.source      o_sym
);
    import a2m_pkg::*;

    logic       r_busy, n_busy;
    logic       r_word, n_word;
    logic [2:0] r_left, n_left;
    logic [5:0] r_pat, n_pat;
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_out_sym, n_out_sym;
    logic       r_out_last, n_out_last;
    logic       adv;
    logic       finishing;

    // Output register advances when empty or taken
    assign adv       = !r_out_valid || o_sym.ready;
    assign finishing = r_busy && (r_left == '0);
    assign o_pop     = adv && (!r_busy || finishing) && i_q_valid;

    always_comb begin
        n_busy      = r_busy;
        n_word      = r_word;
        n_left      = r_left;
        n_pat       = r_pat;
        n_out_valid = r_out_valid;
        n_out_sym   = r_out_sym;
        n_out_last  = r_out_last;
        if (adv) begin
            n_out_valid = r_busy;
            // Emit the next element, or the closing gap
            if (r_busy) begin
                if (r_left != '0) begin
                    n_out_sym  = r_word ? SymWord : (r_pat[5] ? SymDash : SymDot);
                    n_out_last = 1'b0;
                    n_left     = r_left - 1'b1;
                    n_pat      = {r_pat[4:0], 1'b0};
                end else begin
                    n_out_sym  = SymGap;
                    n_out_last = 1'b1;
                    n_busy     = 1'b0;
                end
            end
            // Load the next descriptor
            if (o_pop) begin
                n_busy = 1'b1;
                n_word = i_q_desc.word;
                n_left = i_q_desc.len;
                n_pat  = i_q_desc.pat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload holds no reset
    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_left     <= n_left;
        r_pat      <= n_pat;
        r_out_sym  <= n_out_sym;
        r_out_last <= n_out_last;
    end

    assign o_sym.valid  = r_out_valid;
    assign o_sym.symbol = r_out_sym;
    assign o_sym.last   = r_out_last;
endmodule

// ===== rtl/ascii_to_morse_encoder.sv =====
// ----------------------------------------------------------------------------
// ascii_to_morse_encoder
// ASCII character to International Morse symbol stream encoder.
// ----------------------------------------------------------------------------
//   Channel  Dir  Payload            Transaction
//   i_char   in   char_code[7:0]     one ASCII character
//   o_sym    out  symbol[1:0], last  one Morse symbol, last ends a run
//
// A character with an n-element pattern yields n+1 output symbols, seven at
// most; the back serializer sets the rate, one symbol per unstalled cycle.
// Characters with no pattern are accepted and produce nothing.
// Reset is synchronous, active low, and empties the queue and output stage.
// Input stalls only when the descriptor queue is full; output stalls hold
// the output register and the serializer.
// ----------------------------------------------------------------------------
module ascii_to_morse_encoder #(
    parameter int QueueDepth = a2m_pkg::QDepth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    a2m_char_if.sink  i_char,
    a2m_sym_if.source o_sym
);
    import a2m_pkg::*;

    logic  push;
    t_desc push_desc;
    logic  pop;
    logic  q_full;
    logic  q_valid;
    t_desc q_desc;

    // Classify and enqueue
    a2m_front u_front (
        .i_char      (i_char),
        .i_full      (q_full),
        .o_push      (push),
        .o_push_desc (push_desc)
    );

    // Decouple front from back
    a2m_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_desc (push_desc),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_desc      (q_desc)
    );

    // Serialize into symbols
    a2m_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_desc  (q_desc),
        .o_pop     (pop),
        .o_sym     (o_sym)
    );
endmodule

// ===== tb/sv/ascii_to_morse_checker.sv =====
// ----------------------------------------------------------------------------
// ascii_to_morse_checker
// Watches both channels of the Morse encoder. Each accepted character is
// encoded on the side into its dot/dash/gap sequence. Each accepted symbol
// is then compared, field by field, against the oldest pending symbol.
// ----------------------------------------------------------------------------
module ascii_to_morse_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_char_valid,
    input  logic       i_char_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_sym_valid,
    input  logic       i_sym_ready,
    input  logic [1:0] i_symbol,
    input  logic       i_last,
    output int         o_err_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import a2m_pkg::*;

    localparam int ReportMax = 10;

    typedef struct packed {
        logic [1:0] symbol;
        logic       last;
    } t_morse_sym;

    t_morse_sym pending_syms[$];
    int         err_count = 0;

    assign o_err_count = err_count;
    assign o_pending   = pending_syms.size();

    // Look up the dot/dash pattern of one character, empty if none
    function automatic string morse_pattern(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c >= "a" && c <= "z") begin
            c = c - 8'd32;
        end
        case (c)
            "A": return ".-";     "B": return "-...";   "C": return "-.-.";
            "D": return "-..";    "E": return ".";      "F": return "..-.";
            "G": return "--.";    "H": return "....";   "I": return "..";
            "J": return ".---";   "K": return "-.-";    "L": return ".-..";
            "M": return "--";     "N": return "-.";     "O": return "---";
            "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
            "S": return "...";    "T": return "-";      "U": return "..-";
            "V": return "...-";   "W": return ".--";    "X": return "-..-";
            "Y": return "-.--";   "Z": return "--..";
            "0": return "-----";  "1": return ".----";  "2": return "..---";
            "3": return "...--";  "4": return "....-";  "5": return ".....";
            "6": return "-....";  "7": return "--...";  "8": return "---..";
            "9": return "----.";
            ".": return ".-.-.-"; ",": return "--..--"; ":": return "---...";
            "?": return "..--.."; "-": return "-....-"; "/": return "-..-.";
            ";": return "-.-.-.";
            default: return "";
        endcase
    endfunction

    // Append the symbols one character should produce
    function automatic void queue_morse_char(input logic [7:0] code);
        string      pat;
        t_morse_sym s;
        if (code == CharSpace) begin
            s = '{SymWord, 1'b0};
            pending_syms.push_back(s);
            s = '{SymGap, 1'b1};
            pending_syms.push_back(s);
            return;
        end
        pat = morse_pattern(code);
        if (pat.len() == 0) begin
            return;
        end
        for (int i = 0; i < pat.len(); i++) begin
            s.symbol = (pat[i] == "-") ? SymDash : SymDot;
            s.last   = 1'b0;
            pending_syms.push_back(s);
        end
        s = '{SymGap, 1'b1};
        pending_syms.push_back(s);
    endfunction

    // Predict on input transactions, then check output transactions
    always @(posedge i_clk) begin
        t_morse_sym want;
        if (i_rst_n) begin
            if (i_char_valid && i_char_ready) begin
                queue_morse_char(i_char_code);
            end
            if (i_sym_valid && i_sym_ready) begin
                if (pending_syms.size() == 0) begin
                    err_count++;
                    if (err_count <= ReportMax) begin
                        $display("%0t: unexpected symbol %0d last %0d", $realtime,
                                 i_symbol, i_last);
                    end
                end else begin
                    want = pending_syms.pop_front();
                    if (want.symbol !== i_symbol || want.last !== i_last) begin
                        err_count++;
                        if (err_count <= ReportMax) begin
                            $display({"%0t: mismatch: expected symbol %0d last %0d, ",
                                      "got %0d last %0d"},
                                     $realtime, want.symbol, want.last, i_symbol, i_last);
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/ascii_to_morse_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// ascii_to_morse_encoder_tb
// Feeds characters into the Morse encoder: a directed set covering every
// table entry class, case folding, space, newline and unmapped codes, then
// mostly mapped random text mixed with random bytes. Both channels idle in
// random bursts except near the end. The checker judges the output.
// ----------------------------------------------------------------------------
module ascii_to_morse_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    RandomItems = 145;
    localparam int    QuietItems  = 30;
    localparam int    TailCycles  = 20;
    localparam int    CycleLimit  = 100000;
    localparam string TextSet     =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.,:?-/; ";

    logic i_clk;
    logic i_rst_n;
    bit   quiet = 1'b0;
    int   cycle_count = 0;
    int   err_count;
    int   pending;

    a2m_char_if char_if ();
    a2m_sym_if  sym_if ();

    ascii_to_morse_encoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_sym   (sym_if)
    );

    ascii_to_morse_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (char_if.valid),
        .i_char_ready (char_if.ready),
        .i_char_code  (char_if.char_code),
        .i_sym_valid  (sym_if.valid),
        .i_sym_ready  (sym_if.ready),
        .i_symbol     (sym_if.symbol),
        .i_last       (sym_if.last),
        .o_err_count  (err_count),
        .o_pending    (pending)
    );

    // Clock generation
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stall the symbol channel in random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        sym_if.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                sym_if.ready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                sym_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 3) - 1;
            end else begin
                sym_if.ready <= 1'b1;
            end
        end
    end

    // Drive one character and hold it until the transaction completes
    task automatic send_char(input logic [7:0] code);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            char_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_code <= code;
        do @(posedge i_clk); while (!char_if.ready);
        @(negedge i_clk);
    endtask

    initial begin
        logic [7:0] directed_chars[$];
        int         sent;
        directed_chars = '{"A", "z", "Z", "e", "0", "9", ".", ",", ":", "?", "-", "/",
                           ";", " ", 8'h0A, 8'h00, 8'hFF, 8'h80, 8'h7F, "!", "m",
                           " ", "Q", 8'h60, 8'h7B};
        sent = 0;
        i_rst_n           = 1'b0;
        char_if.valid     = 1'b0;
        char_if.char_code = '0;

        // Hold reset, release on a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed characters: table classes, case folding, unmapped codes
        foreach (directed_chars[i]) begin
            send_char(directed_chars[i]);
        end

        // Random text, mostly mapped characters with some raw bytes
        while (sent < RandomItems) begin
            if (sent >= RandomItems - QuietItems) begin
                quiet = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                send_char(TextSet[$urandom_range(0, TextSet.len() - 1)]);
            end else begin
                send_char(8'($urandom_range(0, 255)));
            end
            sent++;
        end
        char_if.valid <= 1'b0;

        // Drain and let the pipeline settle
        while (pending != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
